>>> rtl/mdh_pkg.sv
package mdh_pkg;

   localparam int QUEUE_DEPTH   = 1024;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int DISPLAY_COLS  = 400;
   localparam int DISPLAY_ROWS  = 300;

   localparam logic [32:0] FRAME_BYTES   = 33'(DISPLAY_COLS * DISPLAY_ROWS * 4);
   localparam logic [63:0] DISPLAY_RESET =
      {32'd0, 16'(DISPLAY_COLS), 16'(DISPLAY_ROWS)};

   localparam logic [31:0] SERIAL_ADDR_RESET  = 32'hA000_03F8;
   localparam logic [31:0] CLOCK_ADDR_RESET   = 32'hA000_0048;
   localparam logic [31:0] KEYBOARD_ADDR_RESET = 32'hA000_0060;
   localparam logic [31:0] DISPLAY_ADDR_RESET = 32'hA000_0100;
   localparam logic [31:0] FRAME_ADDR_RESET   = 32'hA100_0000;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_KEY   = 3'd1,
      OP_READ  = 3'd2,
      OP_WRITE = 3'd3,
      OP_POLL  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      CSR_SERIAL   = 3'd0,
      CSR_CLOCK    = 3'd1,
      CSR_KEYBOARD = 3'd2,
      CSR_DISPLAY  = 3'd3,
      CSR_FRAME    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      LEN_1 = 2'd0,
      LEN_2 = 2'd1,
      LEN_4 = 2'd2,
      LEN_8 = 2'd3
   } len_code_type;

   typedef struct packed {
      logic        bad_mask;
      logic        serial_hit;
      logic        disp_hit;
      logic        frame_hit;
      logic [7:0]  disp_be;
      logic [63:0] disp_data;
      logic [18:0] frame_offset;
      logic [63:0] data;
      logic [1:0]  len_code;
   } wr_route_type;

   function automatic logic [6:0] key_code(input logic [7:0] sc);
      logic [6:0] k;
      case (sc)
         8'd4:   k = 7'd43;
         8'd5:   k = 7'd60;
         8'd6:   k = 7'd58;
         8'd7:   k = 7'd45;
         8'd8:   k = 7'd31;
         8'd9:   k = 7'd46;
         8'd10:  k = 7'd47;
         8'd11:  k = 7'd48;
         8'd12:  k = 7'd36;
         8'd13:  k = 7'd49;
         8'd14:  k = 7'd50;
         8'd15:  k = 7'd51;
         8'd16:  k = 7'd62;
         8'd17:  k = 7'd61;
         8'd18:  k = 7'd37;
         8'd19:  k = 7'd38;
         8'd20:  k = 7'd29;
         8'd21:  k = 7'd32;
         8'd22:  k = 7'd44;
         8'd23:  k = 7'd33;
         8'd24:  k = 7'd35;
         8'd25:  k = 7'd59;
         8'd26:  k = 7'd30;
         8'd27:  k = 7'd57;
         8'd28:  k = 7'd34;
         8'd29:  k = 7'd56;
         8'd30:  k = 7'd15;
         8'd31:  k = 7'd16;
         8'd32:  k = 7'd17;
         8'd33:  k = 7'd18;
         8'd34:  k = 7'd19;
         8'd35:  k = 7'd20;
         8'd36:  k = 7'd21;
         8'd37:  k = 7'd22;
         8'd38:  k = 7'd23;
         8'd39:  k = 7'd24;
         8'd40:  k = 7'd54;
         8'd41:  k = 7'd1;
         8'd42:  k = 7'd27;
         8'd43:  k = 7'd28;
         8'd44:  k = 7'd70;
         8'd45:  k = 7'd25;
         8'd46:  k = 7'd26;
         8'd47:  k = 7'd39;
         8'd48:  k = 7'd40;
         8'd49:  k = 7'd41;
         8'd51:  k = 7'd52;
         8'd52:  k = 7'd53;
         8'd53:  k = 7'd14;
         8'd54:  k = 7'd63;
         8'd55:  k = 7'd64;
         8'd56:  k = 7'd65;
         8'd57:  k = 7'd42;
         8'd58:  k = 7'd2;
         8'd59:  k = 7'd3;
         8'd60:  k = 7'd4;
         8'd61:  k = 7'd5;
         8'd62:  k = 7'd6;
         8'd63:  k = 7'd7;
         8'd64:  k = 7'd8;
         8'd65:  k = 7'd9;
         8'd66:  k = 7'd10;
         8'd67:  k = 7'd11;
         8'd68:  k = 7'd12;
         8'd69:  k = 7'd13;
         8'd73:  k = 7'd77;
         8'd74:  k = 7'd79;
         8'd75:  k = 7'd81;
         8'd76:  k = 7'd78;
         8'd77:  k = 7'd80;
         8'd78:  k = 7'd82;
         8'd79:  k = 7'd76;
         8'd80:  k = 7'd75;
         8'd81:  k = 7'd74;
         8'd82:  k = 7'd73;
         8'd101: k = 7'd68;
         8'd224: k = 7'd67;
         8'd225: k = 7'd55;
         8'd226: k = 7'd69;
         8'd228: k = 7'd72;
         8'd229: k = 7'd66;
         8'd230: k = 7'd71;
         default: k = 7'd0;
      endcase
      return k;
   endfunction

endpackage

>>> rtl/mdh_key_ram.sv
module mdh_key_ram import mdh_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [QPTR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [QPTR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [QUEUE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mdh_write_route.sv
module mdh_write_route import mdh_pkg::*; (
   input  logic [31:0]  bus_address,
   input  logic [63:0]  write_value,
   input  logic [7:0]   byte_enables,
   input  logic [31:0]  serial_address,
   input  logic [31:0]  display_ctl_address,
   input  logic [31:0]  frame_address,
   output wr_route_type route
);

   logic [2:0]  off;
   logic [1:0]  code;
   logic        bad;
   logic [31:0] a;
   logic [3:0]  len;
   logic [7:0]  len_mask;
   logic [63:0] data_sh;
   logic [63:0] data;
   logic [32:0] a_end;
   logic [32:0] disp_end;
   logic [32:0] frame_end;
   logic [2:0]  pos;
   logic [31:0] frame_rel;

   always_comb begin
      bad  = 1'b0;
      off  = 3'd0;
      code = LEN_1;
      case (byte_enables)
         8'h01: begin off = 3'd0; code = LEN_1; end
         8'h02: begin off = 3'd1; code = LEN_1; end
         8'h04: begin off = 3'd2; code = LEN_1; end
         8'h08: begin off = 3'd3; code = LEN_1; end
         8'h10: begin off = 3'd4; code = LEN_1; end
         8'h20: begin off = 3'd5; code = LEN_1; end
         8'h40: begin off = 3'd6; code = LEN_1; end
         8'h80: begin off = 3'd7; code = LEN_1; end
         8'h03: begin off = 3'd0; code = LEN_2; end
         8'h0c: begin off = 3'd2; code = LEN_2; end
         8'h30: begin off = 3'd4; code = LEN_2; end
         8'hc0: begin off = 3'd6; code = LEN_2; end
         8'h0f: begin off = 3'd0; code = LEN_4; end
         8'hf0: begin off = 3'd4; code = LEN_4; end
         8'hff: begin off = 3'd0; code = LEN_8; end
         default: bad = 1'b1;
      endcase
   end

   always_comb begin
      case (code)
         LEN_1:   len_mask = 8'h01;
         LEN_2:   len_mask = 8'h03;
         LEN_4:   len_mask = 8'h0f;
         default: len_mask = 8'hff;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         data[i*8 +: 8] = len_mask[i] ? data_sh[i*8 +: 8] : 8'h00;
      end
   end

   assign len       = 4'd1 << code;
   assign a         = {bus_address[31:3], off};
   assign data_sh   = write_value >> {off, 3'b000};
   assign a_end     = {1'b0, a} + 33'(len);
   assign disp_end  = {1'b0, display_ctl_address} + 33'd8;
   assign frame_end = {1'b0, frame_address} + FRAME_BYTES;
   assign pos       = a[2:0] - display_ctl_address[2:0];
   assign frame_rel = a - frame_address;

   always_comb begin
      route.bad_mask     = bad;
      route.serial_hit   = !bad && code == LEN_1 && a == serial_address;
      route.disp_hit     = !bad && !route.serial_hit && a >= display_ctl_address
                           && a_end <= disp_end;
      route.frame_hit    = !bad && !route.serial_hit && !route.disp_hit
                           && a >= frame_address && a_end <= frame_end;
      route.disp_be      = len_mask << pos;
      route.disp_data    = data << {pos, 3'b000};
      route.frame_offset = frame_rel[18:0];
      route.data         = data;
      route.len_code     = code;
   end

endmodule

>>> rtl/mmio_device_hub.sv
// Memory-mapped device hub: microsecond counter, keyboard queue, 8-byte display
// control register, serial byte port and framebuffer write forwarding. Each
// request (tick, key event, bus read, bus write, screen poll) gives exactly one
// response. One request is accepted per clock cycle unless rsp_ready low stalls
// stage 1; each goes from stage 1 to the response register, and a second request
// is still taken while a finished response waits. The keyboard queue is a
// QUEUE_DEPTH x 8 synchronous RAM holding up to QUEUE_DEPTH-1 keys; its read is
// issued at acceptance and the data joins the response as stage 1 advances. The
// queue RAM is not cleared after reset and no clearing pass runs. The user must
// write address registers via the csr_ port only while the hub is idle; unenforced.
module mmio_device_hub import mdh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_bus_address,
   input  logic [63:0] req_write_value,
   input  logic [7:0]  req_byte_enables,
   input  logic [7:0]  req_key_scancode,
   input  logic        req_key_pressed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_read_value,
   output logic        rsp_serial_valid,
   output logic [7:0]  rsp_serial_byte,
   output logic        rsp_frame_write_valid,
   output logic [18:0] rsp_frame_offset,
   output logic [63:0] rsp_frame_data,
   output logic [1:0]  rsp_frame_length,
   output logic        rsp_refresh_request,
   output logic        rsp_queue_overflow,
   output logic        rsp_bad_mask,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   // address registers
   logic [31:0] serial_addr_ff, serial_addr_in;
   logic [31:0] clock_addr_ff, clock_addr_in;
   logic [31:0] kbd_addr_ff, kbd_addr_in;
   logic [31:0] disp_addr_ff, disp_addr_in;
   logic [31:0] frame_addr_ff, frame_addr_in;

   // device state
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QPTR_W-1:0] tail_ff, tail_in;
   logic [63:0]       disp_ff, disp_in;
   logic [63:0]       usec_ff, usec_in;

   // stage 1: item accepted, queue read in flight
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_kbd_ff;
   logic        s1_is_read_ff;
   logic [63:0] s1_read_value_ff;
   logic        s1_serial_valid_ff;
   logic [7:0]  s1_serial_byte_ff;
   logic        s1_frame_valid_ff;
   logic [18:0] s1_frame_offset_ff;
   logic [63:0] s1_frame_data_ff;
   logic [1:0]  s1_frame_length_ff;
   logic        s1_refresh_ff;
   logic        s1_overflow_ff;
   logic        s1_bad_mask_ff;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_is_read_ff;
   logic [63:0] rsp_read_value_ff;
   logic        rsp_serial_valid_ff;
   logic [7:0]  rsp_serial_byte_ff;
   logic        rsp_frame_valid_ff;
   logic [18:0] rsp_frame_offset_ff;
   logic [63:0] rsp_frame_data_ff;
   logic [1:0]  rsp_frame_length_ff;
   logic        rsp_refresh_ff;
   logic        rsp_overflow_ff;
   logic        rsp_bad_mask_ff;

   logic              accept;
   logic              s1_adv;
   logic              csr_write;
   op_type            op;
   wr_route_type      route;
   logic [6:0]        code;
   logic [QPTR_W-1:0] tail_next;
   logic [QPTR_W-1:0] head_next;
   logic              queue_full;
   logic              queue_empty;
   logic              enq;
   logic              deq;
   logic              ovf;
   logic [31:0]       rd_addr;
   logic              hit_clock;
   logic              hit_kbd;
   logic              hit_disp;
   logic              sync_nz;
   logic [63:0]       read_value;
   logic [7:0]        ram_q;
   logic [63:0]       disp_merged;

   mdh_write_route u_route (
      .bus_address         (req_bus_address),
      .write_value         (req_write_value),
      .byte_enables        (req_byte_enables),
      .serial_address      (serial_addr_ff),
      .display_ctl_address (disp_addr_ff),
      .frame_address       (frame_addr_ff),
      .route               (route)
   );

   mdh_key_ram u_key_ram (
      .clock   (clock),
      .wr_en   (enq),
      .wr_addr (tail_ff),
      .wr_data ({req_key_pressed, code}),
      .rd_en   (deq),
      .rd_addr (head_ff),
      .rd_data (ram_q)
   );

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign op          = op_type'(req_op);
   assign code        = key_code(req_key_scancode);
   assign tail_next   = (tail_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + QPTR_W'(1);
   assign head_next   = (head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QPTR_W'(1);
   assign queue_full  = tail_next == head_ff;
   assign queue_empty = head_ff == tail_ff;
   assign rd_addr     = {req_bus_address[31:3], 3'b000};
   assign hit_clock   = rd_addr == clock_addr_ff;
   assign hit_kbd     = !hit_clock && rd_addr == kbd_addr_ff;
   assign hit_disp    = !hit_clock && !hit_kbd && rd_addr == disp_addr_ff;
   assign sync_nz     = disp_ff[63:32] != 32'd0;

   assign enq = accept && op == OP_KEY && code != 7'd0 && !queue_full;
   assign ovf = op == OP_KEY && code != 7'd0 && queue_full;
   assign deq = accept && op == OP_READ && hit_kbd && !queue_empty;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         disp_merged[i*8 +: 8] = route.disp_be[i] ? route.disp_data[i*8 +: 8]
                                                  : disp_ff[i*8 +: 8];
      end
   end

   always_comb begin
      read_value = 64'd0;
      if (op == OP_READ) begin
         if (hit_clock) begin
            read_value = usec_ff;
         end else if (hit_disp) begin
            read_value = disp_ff;
         end
      end
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      disp_in = disp_ff;
      usec_in = usec_ff;
      if (accept) begin
         case (op)
            OP_TICK: begin
               usec_in = usec_ff + 64'd1;
            end
            OP_KEY: begin
               if (enq) begin
                  tail_in = tail_next;
               end
            end
            OP_READ: begin
               if (deq) begin
                  head_in = head_next;
               end
            end
            OP_WRITE: begin
               if (route.disp_hit) begin
                  disp_in = disp_merged;
               end
            end
            OP_POLL: begin
               if (sync_nz) begin
                  disp_in = {32'd0, disp_ff[31:0]};
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      serial_addr_in = serial_addr_ff;
      clock_addr_in  = clock_addr_ff;
      kbd_addr_in    = kbd_addr_ff;
      disp_addr_in   = disp_addr_ff;
      frame_addr_in  = frame_addr_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_SERIAL:   serial_addr_in = csr_data;
            CSR_CLOCK:    clock_addr_in  = csr_data;
            CSR_KEYBOARD: kbd_addr_in    = csr_data;
            CSR_DISPLAY:  disp_addr_in   = csr_data;
            CSR_FRAME:    frame_addr_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         serial_addr_ff <= SERIAL_ADDR_RESET;
         clock_addr_ff  <= CLOCK_ADDR_RESET;
         kbd_addr_ff    <= KEYBOARD_ADDR_RESET;
         disp_addr_ff   <= DISPLAY_ADDR_RESET;
         frame_addr_ff  <= FRAME_ADDR_RESET;
         head_ff        <= '0;
         tail_ff        <= '0;
         disp_ff        <= DISPLAY_RESET;
         usec_ff        <= 64'd0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         serial_addr_ff <= serial_addr_in;
         clock_addr_ff  <= clock_addr_in;
         kbd_addr_ff    <= kbd_addr_in;
         disp_addr_ff   <= disp_addr_in;
         frame_addr_ff  <= frame_addr_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         disp_ff        <= disp_in;
         usec_ff        <= usec_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kbd_ff          <= deq;
         s1_is_read_ff      <= op == OP_READ;
         s1_read_value_ff   <= read_value;
         s1_serial_valid_ff <= op == OP_WRITE && route.serial_hit;
         s1_serial_byte_ff  <= (op == OP_WRITE && route.serial_hit) ? route.data[7:0]
                                                                   : 8'd0;
         s1_frame_valid_ff  <= op == OP_WRITE && route.frame_hit;
         s1_frame_offset_ff <= (op == OP_WRITE && route.frame_hit) ? route.frame_offset
                                                                  : 19'd0;
         s1_frame_data_ff   <= (op == OP_WRITE && route.frame_hit) ? route.data : 64'd0;
         s1_frame_length_ff <= (op == OP_WRITE && route.frame_hit) ? route.len_code
                                                                  : 2'd0;
         s1_refresh_ff      <= op == OP_POLL && sync_nz;
         s1_overflow_ff     <= ovf;
         s1_bad_mask_ff     <= op == OP_WRITE && route.bad_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_is_read_ff      <= s1_is_read_ff;
         rsp_read_value_ff   <= s1_kbd_ff ? 64'({ram_q[7], 8'd0, ram_q[6:0]})
                                          : s1_read_value_ff;
         rsp_serial_valid_ff <= s1_serial_valid_ff;
         rsp_serial_byte_ff  <= s1_serial_byte_ff;
         rsp_frame_valid_ff  <= s1_frame_valid_ff;
         rsp_frame_offset_ff <= s1_frame_offset_ff;
         rsp_frame_data_ff   <= s1_frame_data_ff;
         rsp_frame_length_ff <= s1_frame_length_ff;
         rsp_refresh_ff      <= s1_refresh_ff;
         rsp_overflow_ff     <= s1_overflow_ff;
         rsp_bad_mask_ff     <= s1_bad_mask_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_value        = rsp_read_value_ff;
   assign rsp_serial_valid      = rsp_serial_valid_ff;
   assign rsp_serial_byte       = rsp_serial_byte_ff;
   assign rsp_frame_write_valid = rsp_frame_valid_ff;
   assign rsp_frame_offset      = rsp_frame_offset_ff;
   assign rsp_frame_data        = rsp_frame_data_ff;
   assign rsp_frame_length      = rsp_frame_length_ff;
   assign rsp_refresh_request   = rsp_refresh_ff;
   assign rsp_queue_overflow    = rsp_overflow_ff;
   assign rsp_bad_mask          = rsp_bad_mask_ff;

   a_single_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_serial_valid_ff, rsp_frame_valid_ff,
                                 rsp_refresh_ff, rsp_overflow_ff, rsp_bad_mask_ff}))
      else $error("more than one event flag in a response");

   a_ram_one_port: assert property (@(posedge clock) disable iff (reset)
      !(enq && deq))
      else $error("queue ram written and read in the same cycle");

   a_enq_nonempty: assert property (@(posedge clock) disable iff (reset)
      enq |=> (head_ff != tail_ff))
      else $error("queue empty right after a key was queued");

   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_TICK) |=> (usec_ff == $past(usec_ff) + 64'd1))
      else $error("tick did not advance the microsecond counter");

   a_read_only_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_read_value_ff != 64'd0) |-> rsp_is_read_ff)
      else $error("read data on a response that is not a bus read");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import mdh_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam logic [63:0] FRAME_SPAN = 64'(DISPLAY_COLS * DISPLAY_ROWS * 4);
   localparam logic [63:0] ALL_ONES = '1;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] addr;
      logic [63:0] wdata;
      logic [7:0]  byte_en;
      logic [7:0]  scancode;
      logic        pressed;
   } hub_req_type;

   typedef struct packed {
      logic [63:0] read_value;
      logic        serial_valid;
      logic [7:0]  serial_byte;
      logic        frame_write_valid;
      logic [18:0] frame_offset;
      logic [63:0] frame_data;
      logic [1:0]  frame_length;
      logic        refresh_request;
      logic        queue_overflow;
      logic        bad_mask;
   } hub_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_op = '0;
   logic [31:0] req_bus_address = '0;
   logic [63:0] req_write_value = '0;
   logic [7:0]  req_byte_enables = '0;
   logic [7:0]  req_key_scancode = '0;
   logic        req_key_pressed = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_read_value;
   logic        rsp_serial_valid;
   logic [7:0]  rsp_serial_byte;
   logic        rsp_frame_write_valid;
   logic [18:0] rsp_frame_offset;
   logic [63:0] rsp_frame_data;
   logic [1:0]  rsp_frame_length;
   logic        rsp_refresh_request;
   logic        rsp_queue_overflow;
   logic        rsp_bad_mask;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_SERIAL;
   logic [31:0] csr_data = '0;

   // predicted device state
   logic [31:0] serial_addr   = SERIAL_ADDR_RESET;
   logic [31:0] clock_addr    = CLOCK_ADDR_RESET;
   logic [31:0] keyboard_addr = KEYBOARD_ADDR_RESET;
   logic [31:0] display_addr  = DISPLAY_ADDR_RESET;
   logic [31:0] frame_addr    = FRAME_ADDR_RESET;
   logic [7:0]  key_ring [0:QUEUE_DEPTH-1];
   int          key_head = 0;
   int          key_tail = 0;
   logic [63:0] disp_ctl = {32'd0, 16'(DISPLAY_COLS), 16'(DISPLAY_ROWS)};
   logic [63:0] usec_count = '0;
   logic [6:0]  key_rom [0:255];

   hub_rsp_type due_rsp [$];
   hub_rsp_type seen_rsp;
   hub_rsp_type owed_rsp;

   bit no_gaps = 1'b0;
   int ready_hold = 0;
   int stall_draw;
   int cycles_run = 0;
   int mismatches = 0;
   int n_items = 0;
   int n_checked = 0;
   int n_csr = 0;
   int n_drops = 0;
   int n_bad = 0;
   int n_serial = 0;
   int n_frame = 0;
   int n_refresh = 0;

   mmio_device_hub u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_op                (req_op),
      .req_bus_address       (req_bus_address),
      .req_write_value       (req_write_value),
      .req_byte_enables      (req_byte_enables),
      .req_key_scancode      (req_key_scancode),
      .req_key_pressed       (req_key_pressed),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_read_value        (rsp_read_value),
      .rsp_serial_valid      (rsp_serial_valid),
      .rsp_serial_byte       (rsp_serial_byte),
      .rsp_frame_write_valid (rsp_frame_write_valid),
      .rsp_frame_offset      (rsp_frame_offset),
      .rsp_frame_data        (rsp_frame_data),
      .rsp_frame_length      (rsp_frame_length),
      .rsp_refresh_request   (rsp_refresh_request),
      .rsp_queue_overflow    (rsp_queue_overflow),
      .rsp_bad_mask          (rsp_bad_mask),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // scancode to key code table
   initial begin
      for (int i = 0; i < 256; i++) key_rom[i] = 7'd0;
      key_rom[4] = 7'd43;   key_rom[5] = 7'd60;   key_rom[6] = 7'd58;   key_rom[7] = 7'd45;
      key_rom[8] = 7'd31;   key_rom[9] = 7'd46;   key_rom[10] = 7'd47;  key_rom[11] = 7'd48;
      key_rom[12] = 7'd36;  key_rom[13] = 7'd49;  key_rom[14] = 7'd50;  key_rom[15] = 7'd51;
      key_rom[16] = 7'd62;  key_rom[17] = 7'd61;  key_rom[18] = 7'd37;  key_rom[19] = 7'd38;
      key_rom[20] = 7'd29;  key_rom[21] = 7'd32;  key_rom[22] = 7'd44;  key_rom[23] = 7'd33;
      key_rom[24] = 7'd35;  key_rom[25] = 7'd59;  key_rom[26] = 7'd30;  key_rom[27] = 7'd57;
      key_rom[28] = 7'd34;  key_rom[29] = 7'd56;  key_rom[30] = 7'd15;  key_rom[31] = 7'd16;
      key_rom[32] = 7'd17;  key_rom[33] = 7'd18;  key_rom[34] = 7'd19;  key_rom[35] = 7'd20;
      key_rom[36] = 7'd21;  key_rom[37] = 7'd22;  key_rom[38] = 7'd23;  key_rom[39] = 7'd24;
      key_rom[40] = 7'd54;  key_rom[41] = 7'd1;   key_rom[42] = 7'd27;  key_rom[43] = 7'd28;
      key_rom[44] = 7'd70;  key_rom[45] = 7'd25;  key_rom[46] = 7'd26;  key_rom[47] = 7'd39;
      key_rom[48] = 7'd40;  key_rom[49] = 7'd41;  key_rom[51] = 7'd52;  key_rom[52] = 7'd53;
      key_rom[53] = 7'd14;  key_rom[54] = 7'd63;  key_rom[55] = 7'd64;  key_rom[56] = 7'd65;
      key_rom[57] = 7'd42;  key_rom[58] = 7'd2;   key_rom[59] = 7'd3;   key_rom[60] = 7'd4;
      key_rom[61] = 7'd5;   key_rom[62] = 7'd6;   key_rom[63] = 7'd7;   key_rom[64] = 7'd8;
      key_rom[65] = 7'd9;   key_rom[66] = 7'd10;  key_rom[67] = 7'd11;  key_rom[68] = 7'd12;
      key_rom[69] = 7'd13;  key_rom[73] = 7'd77;  key_rom[74] = 7'd79;  key_rom[75] = 7'd81;
      key_rom[76] = 7'd78;  key_rom[77] = 7'd80;  key_rom[78] = 7'd82;  key_rom[79] = 7'd76;
      key_rom[80] = 7'd75;  key_rom[81] = 7'd74;  key_rom[82] = 7'd73;  key_rom[101] = 7'd68;
      key_rom[224] = 7'd67; key_rom[225] = 7'd55; key_rom[226] = 7'd69; key_rom[228] = 7'd72;
      key_rom[229] = 7'd66; key_rom[230] = 7'd71;
   end

   function automatic hub_rsp_type compute_response(input hub_req_type it);
      hub_rsp_type r;
      int          next_slot;
      logic [6:0]  code;
      logic [7:0]  entry;
      logic [31:0] line_addr;
      logic [1:0]  len_code;
      bit          mask_ok;
      int unsigned off;
      int unsigned len;
      logic [63:0] a;
      logic [63:0] data;
      logic [63:0] dbase;
      logic [63:0] fbase;
      r = '0;
      line_addr = {it.addr[31:3], 3'b000};
      case (it.op)
         OP_TICK: usec_count = usec_count + 64'd1;
         OP_KEY: begin
            code = key_rom[it.scancode];
            if (code != 7'd0) begin
               next_slot = (key_tail + 1 == QUEUE_DEPTH) ? 0 : key_tail + 1;
               if (next_slot == key_head) begin
                  r.queue_overflow = 1'b1;
                  n_drops++;
               end else begin
                  key_ring[key_tail] = {it.pressed, code};
                  key_tail = next_slot;
               end
            end
         end
         OP_READ: begin
            if (line_addr == clock_addr) begin
               r.read_value = usec_count;
            end else if (line_addr == keyboard_addr) begin
               if (key_head != key_tail) begin
                  entry = key_ring[key_head];
                  r.read_value = {48'd0, entry[7], 8'd0, entry[6:0]};
                  key_head = (key_head + 1 == QUEUE_DEPTH) ? 0 : key_head + 1;
               end
            end else if (line_addr == display_addr) begin
               r.read_value = disp_ctl;
            end
         end
         OP_WRITE: begin
            mask_ok = 1'b1;
            case (it.byte_en)
               8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80: len_code = LEN_1;
               8'h03, 8'h0c, 8'h30, 8'hc0: len_code = LEN_2;
               8'h0f, 8'hf0: len_code = LEN_4;
               8'hff: len_code = LEN_8;
               default: begin
                  len_code = LEN_1;
                  mask_ok = 1'b0;
               end
            endcase
            if (!mask_ok) begin
               r.bad_mask = 1'b1;
               n_bad++;
            end else begin
               off = 0;
               for (int b = 7; b >= 0; b--) if (it.byte_en[b]) off = b;
               len = 32'd1 << len_code;
               a = 64'(line_addr) + 64'(off);
               data = it.wdata >> (8 * off);
               if (len < 8) data = data & ((64'd1 << (8 * len)) - 64'd1);
               dbase = 64'(display_addr);
               fbase = 64'(frame_addr);
               if (a == 64'(serial_addr) && len == 1) begin
                  r.serial_valid = 1'b1;
                  r.serial_byte = data[7:0];
                  n_serial++;
               end else if (dbase <= a && a + 64'(len) <= dbase + 64'd8) begin
                  for (int k = 0; k < int'(len); k++)
                     disp_ctl[8 * (int'(a - dbase) + k) +: 8] = data[8 * k +: 8];
               end else if (fbase <= a && a + 64'(len) <= fbase + FRAME_SPAN) begin
                  r.frame_write_valid = 1'b1;
                  r.frame_offset = 19'(a - fbase);
                  r.frame_data = data;
                  r.frame_length = len_code;
                  n_frame++;
               end
            end
         end
         OP_POLL: begin
            if (disp_ctl[63:32] != 32'd0) begin
               r.refresh_request = 1'b1;
               disp_ctl[63:32] = '0;
               n_refresh++;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic hub_req_type req_of(input logic [2:0] op, input logic [31:0] addr,
                                          input logic [63:0] wdata, input logic [7:0] be,
                                          input logic [7:0] sc, input logic pressed);
      hub_req_type it;
      it.op = op;
      it.addr = addr;
      it.wdata = wdata;
      it.byte_en = be;
      it.scancode = sc;
      it.pressed = pressed;
      return it;
   endfunction

   function automatic logic [7:0] mapped_scancode();
      logic [7:0] sc;
      sc = 8'($urandom_range(0, 255));
      while (key_rom[sc] == 7'd0) sc = 8'($urandom_range(0, 255));
      return sc;
   endfunction

   // aim accesses at device registers and window edges most of the time
   function automatic logic [31:0] target_address();
      logic [31:0] base;
      case ($urandom_range(0, 9))
         0: base = clock_addr;
         1, 2: base = keyboard_addr;
         3: base = display_addr;
         4: base = serial_addr;
         5, 6: base = frame_addr + 32'($urandom_range(0, 32'(FRAME_SPAN) - 1));
         7: base = 32'(64'(frame_addr) + FRAME_SPAN - 64'($urandom_range(1, 16)));
         8: base = display_addr + 32'($urandom_range(0, 23)) - 32'd8;
         default: base = 32'($urandom);
      endcase
      return {base[31:3], 3'($urandom_range(0, 7))};
   endfunction

   function automatic hub_req_type random_request();
      hub_req_type it;
      int unsigned pick;
      int unsigned lc;
      int unsigned w;
      int unsigned slot;
      it = req_of(OP_TICK, 32'($urandom), {$urandom, $urandom}, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         it.op = OP_TICK;
      end else if (pick < 30) begin
         it.op = OP_KEY;
         if ($urandom_range(0, 4) != 0) it.scancode = mapped_scancode();
      end else if (pick < 60) begin
         it.op = OP_READ;
         it.addr = target_address();
      end else if (pick < 90) begin
         it.op = OP_WRITE;
         it.addr = target_address();
         if ($urandom_range(0, 6) != 0) begin
            lc = $urandom_range(0, 3);
            w = 1 << lc;
            slot = $urandom_range(0, (8 >> lc) - 1);
            it.byte_en = 8'(((1 << w) - 1) << (slot * w));
         end
         if (it.addr[31:3] == serial_addr[31:3] && $urandom_range(0, 2) != 0)
            it.byte_en = 8'd1 << serial_addr[2:0];
      end else if (pick < 97) begin
         it.op = OP_POLL;
      end else begin
         it.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      return it;
   endfunction

   task automatic send_item(input hub_req_type it);
      int unsigned gap;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op <= it.op;
      req_bus_address <= it.addr;
      req_write_value <= it.wdata;
      req_byte_enables <= it.byte_en;
      req_key_scancode <= it.scancode;
      req_key_pressed <= it.pressed;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      due_rsp.push_back(compute_response(it));
      n_items++;
   endtask

   task automatic apply_csr(input csr_index_type idx, input logic [31:0] value);
      req_valid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SERIAL:   serial_addr = value;
         CSR_CLOCK:    clock_addr = value;
         CSR_KEYBOARD: keyboard_addr = value;
         CSR_DISPLAY:  display_addr = value;
         CSR_FRAME:    frame_addr = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      n_csr++;
   endtask

   task automatic load_addresses(input logic [31:0] s, input logic [31:0] c,
                                 input logic [31:0] k, input logic [31:0] d,
                                 input logic [31:0] f);
      apply_csr(CSR_SERIAL, s);
      apply_csr(CSR_CLOCK, c);
      apply_csr(CSR_KEYBOARD, k);
      apply_csr(CSR_DISPLAY, d);
      apply_csr(CSR_FRAME, f);
   endtask

   task automatic test_random_traffic(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         send_item(random_request());
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_directed();
      logic [31:0] frame_end;
      frame_end = FRAME_ADDR_RESET + 32'(FRAME_SPAN);
      send_item(req_of(OP_TICK, 32'hFFFF_FFFF, ALL_ONES, 8'hFF, 8'hFF, 1'b1));
      send_item(req_of(OP_READ, CLOCK_ADDR_RESET | 32'd5, '0, '0, '0, 1'b0));
      send_item(req_of(OP_KEY, '0, '0, '0, 8'd4, 1'b1));
      send_item(req_of(OP_KEY, '0, '0, '0, 8'd0, 1'b1));
      send_item(req_of(OP_KEY, '0, '0, '0, 8'd255, 1'b0));
      send_item(req_of(OP_KEY, '0, '0, '0, 8'd230, 1'b0));
      // two keys out, then an empty queue reads zero
      repeat (3) send_item(req_of(OP_READ, KEYBOARD_ADDR_RESET, '0, '0, '0, 1'b0));
      send_item(req_of(OP_READ, DISPLAY_ADDR_RESET | 32'd7, '0, '0, '0, 1'b0));
      send_item(req_of(OP_WRITE, DISPLAY_ADDR_RESET, ALL_ONES, 8'hF0, '0, 1'b0));
      repeat (2) send_item(req_of(OP_POLL, '0, '0, '0, '0, 1'b0));
      send_item(req_of(OP_WRITE, DISPLAY_ADDR_RESET, 64'h0123_4567_89AB_CDEF, 8'h0C, '0, 1'b0));
      send_item(req_of(OP_READ, DISPLAY_ADDR_RESET, '0, '0, '0, 1'b0));
      send_item(req_of(OP_WRITE, SERIAL_ADDR_RESET, 64'h41, 8'h01, '0, 1'b0));
      send_item(req_of(OP_WRITE, SERIAL_ADDR_RESET, 64'h4142, 8'h03, '0, 1'b0));
      send_item(req_of(OP_WRITE, FRAME_ADDR_RESET, ALL_ONES, 8'hFF, '0, 1'b0));
      send_item(req_of(OP_WRITE, frame_end - 32'd8, 64'hFEDC_BA98_7654_3210, 8'h80, '0, 1'b0));
      send_item(req_of(OP_WRITE, frame_end - 32'd8, 64'hFEDC_BA98_7654_3210, 8'hF0, '0, 1'b0));
      send_item(req_of(OP_WRITE, frame_end, ALL_ONES, 8'h01, '0, 1'b0));
      send_item(req_of(OP_WRITE, DISPLAY_ADDR_RESET, ALL_ONES, 8'h00, '0, 1'b0));
      send_item(req_of(OP_WRITE, DISPLAY_ADDR_RESET, ALL_ONES, 8'h05, '0, 1'b0));
      send_item(req_of(OP_READ, '0, '0, '0, '0, 1'b0));
      send_item(req_of(OP_SPARE_HI, 32'hFFFF_FFFF, ALL_ONES, 8'hFF, 8'hFF, 1'b1));
   endtask

   task automatic test_csr_sweep();
      // everything at zero: overlapping devices resolve by priority
      load_addresses('0, '0, '0, '0, '0);
      test_random_traffic(60);
      load_addresses(32'hFFFF_FFFF, 32'hFFFF_FFF8, 32'hFFFF_FFF0, 32'hFFFF_FFE8, 32'hFFFF_FFF8);
      test_random_traffic(60);
      // frame window runs past the top of the address space over the display
      load_addresses(32'hFFFF_FFFB, 32'h0000_0008, 32'hFFFF_FFF8, 32'hFFFF_FFF8, 32'hFFF9_0000);
      test_random_traffic(60);
      load_addresses(32'($urandom), 32'($urandom) & ~32'd7, 32'($urandom) & ~32'd7,
                     32'($urandom) & ~32'd7, 32'($urandom) & ~32'd7);
      test_random_traffic(60);
      load_addresses(SERIAL_ADDR_RESET, CLOCK_ADDR_RESET, KEYBOARD_ADDR_RESET,
                     DISPLAY_ADDR_RESET, FRAME_ADDR_RESET);
   endtask

   task automatic test_queue_full();
      hub_req_type it;
      while ((key_tail - key_head + QUEUE_DEPTH) % QUEUE_DEPTH < QUEUE_DEPTH - 1) begin
         it = req_of(OP_KEY, 32'($urandom), {$urandom, $urandom}, 8'($urandom_range(0, 255)),
                     mapped_scancode(), 1'($urandom_range(0, 1)));
         send_item(it);
      end
      repeat (4) send_item(req_of(OP_KEY, '0, '0, '0, mapped_scancode(), 1'b1));
      repeat (40) begin
         send_item(req_of(OP_READ, keyboard_addr, '0, '0, '0, 1'b0));
         if ($urandom_range(0, 1) == 1)
            send_item(req_of(OP_KEY, '0, '0, '0, mapped_scancode(), 1'($urandom_range(0, 1))));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold <= 0;
      end else if (rsp_valid && rsp_ready) begin
         stall_draw = no_gaps ? 0 : $urandom_range(0, 7);
         if (stall_draw != 0) begin
            rsp_ready <= 1'b0;
            ready_hold <= stall_draw - 1;
         end
      end else if (!rsp_ready) begin
         if (ready_hold == 0) rsp_ready <= 1'b1;
         else ready_hold <= ready_hold - 1;
      end
   end

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("response %0d %s: expected %h, got %h", n_checked, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_rsp.read_value = rsp_read_value;
         seen_rsp.serial_valid = rsp_serial_valid;
         seen_rsp.serial_byte = rsp_serial_byte;
         seen_rsp.frame_write_valid = rsp_frame_write_valid;
         seen_rsp.frame_offset = rsp_frame_offset;
         seen_rsp.frame_data = rsp_frame_data;
         seen_rsp.frame_length = rsp_frame_length;
         seen_rsp.refresh_request = rsp_refresh_request;
         seen_rsp.queue_overflow = rsp_queue_overflow;
         seen_rsp.bad_mask = rsp_bad_mask;
         if (due_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d arrived with nothing outstanding", n_checked);
         end else begin
            owed_rsp = due_rsp.pop_front();
            check_field("read_value", owed_rsp.read_value, seen_rsp.read_value);
            check_field("serial_valid", 64'(owed_rsp.serial_valid), 64'(seen_rsp.serial_valid));
            check_field("serial_byte", 64'(owed_rsp.serial_byte), 64'(seen_rsp.serial_byte));
            check_field("frame_write_valid", 64'(owed_rsp.frame_write_valid),
                        64'(seen_rsp.frame_write_valid));
            check_field("frame_offset", 64'(owed_rsp.frame_offset), 64'(seen_rsp.frame_offset));
            check_field("frame_data", owed_rsp.frame_data, seen_rsp.frame_data);
            check_field("frame_length", 64'(owed_rsp.frame_length), 64'(seen_rsp.frame_length));
            check_field("refresh_request", 64'(owed_rsp.refresh_request),
                        64'(seen_rsp.refresh_request));
            check_field("queue_overflow", 64'(owed_rsp.queue_overflow),
                        64'(seen_rsp.queue_overflow));
            check_field("bad_mask", 64'(owed_rsp.bad_mask), 64'(seen_rsp.bad_mask));
         end
         n_checked++;
      end
   end

   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("run stopped after %0d cycles with %0d responses outstanding",
               cycles_run, due_rsp.size());
      $display("FAIL mmio_device_hub");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(80);
      test_csr_sweep();
      test_queue_full();
      test_random_traffic(50);
      req_valid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d requests over five address maps and a full key queue, %0d register writes",
               n_items, n_csr);
      $display("%0d responses checked: %0d serial, %0d frame, %0d bad mask,",
               n_checked, n_serial, n_frame, n_bad);
      $display("%0d dropped keys, %0d refresh, %0d mismatches",
               n_drops, n_refresh, mismatches);
      if (mismatches == 0 && due_rsp.size() == 0) begin
         $display("PASS mmio_device_hub");
      end else begin
         $display("FAIL mmio_device_hub");
      end
      $finish;
   end

endmodule
